// ----- hdl/lz77g_pkg.sv -----
// Shared types and constants for the LZ77 group decompressor.
package lz77g_pkg;

  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int DIST_W    = WIN_AW + 1;
  localparam int LEN_W     = 9;

  localparam logic [LEN_W-1:0] SHORT_LEN_BIAS = LEN_W'(2);
  localparam logic [LEN_W-1:0] LONG_LEN_BIAS  = LEN_W'(8'h12);

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_REF = 2'd1;
  localparam logic [1:0] STATUS_TRUNC   = 2'd2;

  localparam logic [1:0] PH_NONE   = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_WR    = 5'b00100,
    S_FLUSH = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [WIN_AW-1:0] raddr;
    logic [DIST_W-1:0] reach;
  } win_req_t;

endpackage

// ----- hdl/lz77g_window.sv -----
// History window: byte memory with one write and one read port, and a fill count masking unwritten entries.
module lz77g_window (
  input  logic                clk,
  input  logic                rst_n,
  input  lz77g_pkg::win_req_t req,
  output logic [7:0]          rdata
);

  logic [7:0]                 mem [lz77g_pkg::WIN_DEPTH];
  logic [7:0]                 rdata_r;
  logic                       hit_r;
  logic [lz77g_pkg::DIST_W-1:0] fill_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  // fill saturates at the depth; a distance past it points before the start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      hit_r  <= 1'b0;
    end else begin
      if (req.we && fill_r != lz77g_pkg::DIST_W'(lz77g_pkg::WIN_DEPTH)) begin
        fill_r <= fill_r + lz77g_pkg::DIST_W'(1);
      end
      if (req.re) begin
        hit_r <= (fill_r >= req.reach);
      end
    end
  end

  assign rdata = hit_r ? rdata_r : 8'h00;

endmodule

// ----- hdl/lz77_group_decompressor.sv -----
// Top level of the LZ77 group decompressor: byte decoder, copy sequencer, output word register.
// Layout and token bytes that decode nothing are only accepted (then emitted if they end the
// stream), and a byte after the end is dropped; a literal is accepted, then emitted. A
// back-reference is accepted, then each byte takes a read and a write of the window, then a
// closing check and the emit follow, with a flush of each full word before the last.
// Output stalls add cycles; the input is held off while a copy or emit is in flight.
// Reset (rst_n, synchronous, active low) clears control state and the window fill count;
// unwritten history reads as zero through the fill count, so there is no clearing pass.
module lz77_group_decompressor #(
  parameter int OUT_LANES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_run_last,
  output logic        out_stream_done,
  output logic [1:0]  out_status
);

  localparam int AW = lz77g_pkg::WIN_AW;
  localparam int DW = lz77g_pkg::DIST_W;
  localparam int LW = lz77g_pkg::LEN_W;

  lz77g_pkg::state_t state_r, state_nxt;

  logic [31:0]   ulen_r;
  logic [31:0]   pc_r, pc_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [7:0]    layout_r, layout_nxt;
  logic [3:0]    rem_r, rem_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    tok0_r, tok0_nxt;
  logic [7:0]    tok1_r, tok1_nxt;
  logic          finished_r, finished_nxt;
  logic          last_r, last_nxt;
  logic          force_done_r, force_done_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [DW-1:0] dist_r, dist_nxt;
  logic [7:0]    buf_r [OUT_LANES];
  logic [7:0]    buf_nxt [OUT_LANES];
  logic [3:0]    nbuf_r, nbuf_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_bytes_r, out_bytes_nxt;
  logic [3:0]    out_count_r, out_count_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_done_r, out_done_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  lz77g_pkg::win_req_t win_req;
  logic [7:0]          win_rdata;

  logic slot_free;
  logic load;
  logic put_en;
  logic [7:0] put_byte;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == lz77g_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  lz77g_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (win_req),
    .rdata (win_rdata)
  );

  always_comb begin
    logic [DW-1:0] start_dist;
    logic          start_copy;
    logic [LW-1:0] start_len;
    logic          done;

    state_nxt      = state_r;
    pc_nxt         = pc_r;
    wp_nxt         = wp_r;
    layout_nxt     = layout_r;
    rem_nxt        = rem_r;
    phase_nxt      = phase_r;
    tok0_nxt       = tok0_r;
    tok1_nxt       = tok1_r;
    finished_nxt   = finished_r;
    last_nxt       = last_r;
    force_done_nxt = force_done_r;
    status_nxt     = status_r;
    len_nxt        = len_r;
    dist_nxt       = dist_r;
    nbuf_nxt       = nbuf_r;
    win_req        = '0;
    load           = 1'b0;
    put_en         = 1'b0;
    put_byte       = win_rdata;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    out_status_nxt = out_status_r;
    start_dist     = '0;
    start_copy     = 1'b0;
    start_len      = '0;
    done           = 1'b0;

    case (state_r)
      lz77g_pkg::S_IDLE: begin
        if (in_valid) begin
          last_nxt       = in_last_byte;
          force_done_nxt = 1'b0;
          status_nxt     = lz77g_pkg::STATUS_OK;
          nbuf_nxt       = '0;
          if (finished_r) begin
            // stream over: byte dropped
          end else if (pc_r >= ulen_r) begin
            force_done_nxt = 1'b1;
            state_nxt      = lz77g_pkg::S_EMIT;
          end else if (rem_r == 4'd0) begin
            layout_nxt = in_byte;
            rem_nxt    = 4'd8;
            if (in_last_byte) state_nxt = lz77g_pkg::S_EMIT;
          end else if (phase_r == lz77g_pkg::PH_NONE) begin
            if (layout_r[7]) begin
              // literal
              win_req.we    = 1'b1;
              win_req.waddr = wp_r;
              win_req.wdata = in_byte;
              put_en        = 1'b1;
              put_byte      = in_byte;
              nbuf_nxt      = 4'd1;
              wp_nxt        = wp_r + AW'(1);
              pc_nxt        = pc_r + 32'd1;
              layout_nxt    = {layout_r[6:0], 1'b0};
              rem_nxt       = rem_r - 4'd1;
              state_nxt     = lz77g_pkg::S_EMIT;
            end else begin
              tok0_nxt  = in_byte;
              phase_nxt = lz77g_pkg::PH_SECOND;
              if (in_last_byte) begin
                status_nxt = lz77g_pkg::STATUS_TRUNC;
                state_nxt  = lz77g_pkg::S_EMIT;
              end
            end
          end else if (phase_r == lz77g_pkg::PH_SECOND) begin
            tok1_nxt = in_byte;
            if (tok0_r[7:4] == 4'd0) begin
              phase_nxt = lz77g_pkg::PH_THIRD;
              if (in_last_byte) begin
                status_nxt = lz77g_pkg::STATUS_TRUNC;
                state_nxt  = lz77g_pkg::S_EMIT;
              end
            end else begin
              start_copy = 1'b1;
              start_len  = LW'(tok0_r[7:4]) + lz77g_pkg::SHORT_LEN_BIAS;
              start_dist = {1'b0, tok0_r[3:0], in_byte} + DW'(1);
            end
          end else begin
            start_copy = 1'b1;
            start_len  = LW'(in_byte) + lz77g_pkg::LONG_LEN_BIAS;
            start_dist = {1'b0, tok0_r[3:0], tok1_r} + DW'(1);
          end

          if (start_copy) begin
            len_nxt    = start_len;
            dist_nxt   = start_dist;
            status_nxt = ({{(32-DW){1'b0}}, start_dist} > pc_r) ?
                         lz77g_pkg::STATUS_BAD_REF : lz77g_pkg::STATUS_OK;
            phase_nxt  = lz77g_pkg::PH_NONE;
            layout_nxt = {layout_r[6:0], 1'b0};
            rem_nxt    = rem_r - 4'd1;
            state_nxt  = lz77g_pkg::S_RD;
          end
        end
      end

      lz77g_pkg::S_RD: begin
        if (len_r == '0 || pc_r == ulen_r) begin
          state_nxt = lz77g_pkg::S_EMIT;
        end else if (nbuf_r == 4'(OUT_LANES)) begin
          state_nxt = lz77g_pkg::S_FLUSH;
        end else begin
          win_req.re    = 1'b1;
          win_req.raddr = wp_r - AW'(dist_r);
          win_req.reach = dist_r;
          state_nxt     = lz77g_pkg::S_WR;
        end
      end

      lz77g_pkg::S_WR: begin
        win_req.we    = 1'b1;
        win_req.waddr = wp_r;
        win_req.wdata = win_rdata;
        put_en        = 1'b1;
        nbuf_nxt      = nbuf_r + 4'd1;
        wp_nxt        = wp_r + AW'(1);
        pc_nxt        = pc_r + 32'd1;
        len_nxt       = len_r - LW'(1);
        state_nxt     = lz77g_pkg::S_RD;
      end

      lz77g_pkg::S_FLUSH: begin
        if (slot_free) begin
          load           = 1'b1;
          out_count_nxt  = nbuf_r;
          out_last_nxt   = 1'b0;
          out_done_nxt   = 1'b0;
          out_status_nxt = status_r;
          nbuf_nxt       = '0;
          state_nxt      = lz77g_pkg::S_RD;
        end
      end

      lz77g_pkg::S_EMIT: begin
        if (slot_free) begin
          done           = force_done_r || last_r || (pc_r == ulen_r);
          load           = 1'b1;
          out_count_nxt  = nbuf_r;
          out_last_nxt   = 1'b1;
          out_done_nxt   = done;
          out_status_nxt = status_r;
          nbuf_nxt       = '0;
          finished_nxt   = done;
          if (done) phase_nxt = lz77g_pkg::PH_NONE;
          state_nxt      = lz77g_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lz77g_pkg::S_IDLE;
      end
    endcase
  end

  // lane buffer and output word assembly
  always_comb begin
    for (int j = 0; j < OUT_LANES; j++) begin
      buf_nxt[j] = (put_en && nbuf_r == 4'(j)) ? put_byte : buf_r[j];
    end
    out_bytes_nxt = out_bytes_r;
    if (load) begin
      out_bytes_nxt = '0;
      for (int j = 0; j < OUT_LANES; j++) begin
        if (4'(j) < nbuf_r) out_bytes_nxt[8*j +: 8] = buf_r[j];
      end
    end
    out_valid_nxt = load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lz77g_pkg::S_IDLE;
      ulen_r       <= '0;
      pc_r         <= '0;
      wp_r         <= '0;
      layout_r     <= '0;
      rem_r        <= '0;
      phase_r      <= lz77g_pkg::PH_NONE;
      tok0_r       <= '0;
      tok1_r       <= '0;
      finished_r   <= 1'b0;
      last_r       <= 1'b0;
      force_done_r <= 1'b0;
      nbuf_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_valid && cfg_ready) ulen_r <= cfg_data;
      pc_r         <= pc_nxt;
      wp_r         <= wp_nxt;
      layout_r     <= layout_nxt;
      rem_r        <= rem_nxt;
      phase_r      <= phase_nxt;
      tok0_r       <= tok0_nxt;
      tok1_r       <= tok1_nxt;
      finished_r   <= finished_nxt;
      last_r       <= last_nxt;
      force_done_r <= force_done_nxt;
      nbuf_r       <= nbuf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    len_r        <= len_nxt;
    dist_r       <= dist_nxt;
    buf_r        <= buf_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
    out_done_r   <= out_done_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_bytes       = out_bytes_r;
  assign out_byte_count  = out_count_r;
  assign out_run_last    = out_last_r;
  assign out_stream_done = out_done_r;
  assign out_status      = out_status_r;

  // write phase of a copied byte always follows its read
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lz77g_pkg::S_WR |-> $past(state_r == lz77g_pkg::S_RD))
    else $error("copy write without preceding read");

  // mid-run words are always full
  a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> out_byte_count == 4'(OUT_LANES))
    else $error("partial word before end of run");

  // end of stream only on the closing word of a run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done |-> out_run_last)
    else $error("stream_done on a non-final word");

  // lane buffer never overfills
  a_nbuf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nbuf_r <= 4'(OUT_LANES))
    else $error("lane buffer overrun");

  // nothing new accepted once the stream is over
  a_finished_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r && state_r == lz77g_pkg::S_IDLE |=> state_r == lz77g_pkg::S_IDLE)
    else $error("activity after stream end");

endmodule
